@@ rtl/cmx_pkg.sv @@
// cmx_pkg: widths, register map and controller states of the colour matrix crossfade
// used by cmx_coef_if and by color_matrix_crossfade
// no dependencies
package cmx_pkg;

	localparam int NUM_COEFS  = 12;
	localparam int LANES      = 4;
	localparam int NUM_BANKS  = NUM_COEFS / LANES;
	localparam int COEF_W     = 16;
	localparam int IDX_W      = 4;
	localparam int LANE_W     = 2;
	localparam int BANK_W     = IDX_W - LANE_W;
	localparam int FRAME_W    = 16;
	localparam int APB_AW     = 6;
	localparam int APB_DW     = 64;
	localparam int REG_IDX_W  = 3;
	localparam int NUM_W      = 35;
	localparam int MAG_W      = 34;
	localparam int STEP_W     = 6;

	localparam logic [FRAME_W-1:0] FADE_FRAMES_RESET = 16'd30;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_START_LOW,
		REG_START_MID,
		REG_START_HIGH,
		REG_END_LOW,
		REG_END_MID,
		REG_END_HIGH,
		REG_FADE_FRAMES
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_ABS,
		ST_DIV,
		ST_PUT
	} fsm_state_t;

endpackage

@@ rtl/cmx_tick_if.sv @@
// cmx_tick_if: frame tick channel, valid/ready with the restart flag
// depends on nothing
interface cmx_tick_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

@@ rtl/cmx_coef_if.sv @@
// cmx_coef_if: coefficient result channel, valid/ready with index, value and frame flags
// depends on cmx_pkg
interface cmx_coef_if;
	logic                                 valid;
	logic                                 ready;
	logic        [cmx_pkg::IDX_W-1:0]     coef_index;
	logic signed [cmx_pkg::COEF_W-1:0]    coef_value;
	logic                                 last_of_frame;
	logic                                 fade_done;

	modport source (output valid, output coef_index, output coef_value,
		output last_of_frame, output fade_done, input ready);
	modport sink (input valid, input coef_index, input coef_value,
		input last_of_frame, input fade_done, output ready);
endinterface

@@ rtl/color_matrix_crossfade.sv @@
// color_matrix_crossfade: fades twelve matrix coefficients from a start set to an end set
// depends on cmx_pkg, cmx_tick_if and cmx_coef_if
//
// usage: tick carries one transfer per video frame; restart=1 reloads the frame counter
// from fade_frames and starts a fade. while fading, each tick yields twelve transfers on
// coef (index 0..11, last_of_frame on index 11, fade_done on every result of the final
// frame); an idle tick yields nothing. configuration is a 64-bit apb port, register i at
// byte address 8*i; its registers are to be written only while the block is idle, which
// the block itself does not enforce. each coefficient is (start*count + end*(frames-count))
// / frames, found by a bit-serial multiply over the 16-bit count and frames and a restoring
// divide of the 34-bit magnitude, one bit per cycle, passing through the load, multiply,
// magnitude, divide and output states. tick is taken only while the controller is idle, so
// an active tick is not taken until the last result of the previous frame has been loaded
// into the output register, while idle ticks can be taken back to back.
// the output register lets the next coefficient be computed while a result waits; a
// stalled receiver holds the controller in its output state until the register is free.
// reset clears the fade state and registers, sets fade_frames to 30 and empties the output.
module color_matrix_crossfade (
	input  logic                          clk,
	input  logic                          arst_n,
	cmx_tick_if.sink                      tick,
	cmx_coef_if.source                    coef,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cmx_pkg::APB_AW-1:0]    paddr,
	input  logic [cmx_pkg::APB_DW-1:0]    pwdata,
	output logic [cmx_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);
	import cmx_pkg::*;

	fsm_state_t state_q, state_d;

	logic [NUM_BANKS-1:0][APB_DW-1:0] start_q;
	logic [NUM_BANKS-1:0][APB_DW-1:0] end_q;
	logic [FRAME_W-1:0]               fade_frames_q;
	logic [FRAME_W-1:0]               frames_left_q;
	logic                             fading_q;

	logic [FRAME_W-1:0]               count_q;
	logic [FRAME_W-1:0]               frames_q;
	logic                             done_q;
	logic [IDX_W-1:0]                 idx_q;
	logic signed [COEF_W-1:0]         e_q;
	logic signed [COEF_W:0]           d_q;
	logic [FRAME_W-1:0]               f_sh_q;
	logic [FRAME_W-1:0]               c_sh_q;
	logic signed [NUM_W-1:0]          acc_q;
	logic [MAG_W-1:0]                 dvd_q;
	logic [FRAME_W-1:0]               rem_q;
	logic                             neg_q;
	logic [STEP_W-1:0]                step_q;

	logic                             out_valid_q;
	logic [IDX_W-1:0]                 out_idx_q;
	logic signed [COEF_W-1:0]         out_val_q;
	logic                             out_last_q;
	logic                             out_done_q;

	logic                             tick_xfer;
	logic                             eff_fading;
	logic [FRAME_W-1:0]               eff_left;
	logic                             out_free;
	logic                             load_out;
	logic                             mul_last;
	logic                             div_last;
	logic                             idx_last;
	logic                             cfg_wr;
	cfg_reg_t                         cfg_sel;

	logic [BANK_W-1:0]                bank;
	logic [LANE_W-1:0]                lane;
	logic signed [COEF_W-1:0]         s_sel;
	logic signed [COEF_W-1:0]         e_sel;

	logic signed [NUM_W-1:0]          add_e;
	logic signed [NUM_W-1:0]          add_d;
	logic signed [NUM_W-1:0]          acc_next;
	logic signed [NUM_W-1:0]          acc_abs;
	logic [FRAME_W:0]                 shifted;
	logic [FRAME_W+1:0]               diff;
	logic                             q_bit;
	logic [COEF_W-1:0]                q_mag;
	logic signed [COEF_W-1:0]         q_val;

	// apb register file
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_sel = cfg_reg_t'(paddr[APB_AW-1:APB_AW-REG_IDX_W]);

	always_comb begin
		unique case (cfg_sel)
			REG_START_LOW:   prdata = start_q[0];
			REG_START_MID:   prdata = start_q[1];
			REG_START_HIGH:  prdata = start_q[2];
			REG_END_LOW:     prdata = end_q[0];
			REG_END_MID:     prdata = end_q[1];
			REG_END_HIGH:    prdata = end_q[2];
			REG_FADE_FRAMES: prdata = {{(APB_DW-FRAME_W){1'b0}}, fade_frames_q};
			default:         prdata = '0;
		endcase
	end

	// tick and frame bookkeeping
	assign tick_xfer  = tick.valid && tick.ready;
	assign eff_fading = tick.restart || fading_q;
	assign eff_left   = tick.restart ? fade_frames_q : frames_left_q;
	assign out_free   = !out_valid_q || coef.ready;
	assign mul_last   = (step_q == STEP_W'(FRAME_W - 1));
	assign div_last   = (step_q == STEP_W'(MAG_W - 1));
	assign idx_last   = (idx_q == IDX_W'(NUM_COEFS - 1));

	// coefficient selection
	assign bank  = idx_q[IDX_W-1:LANE_W];
	assign lane  = idx_q[LANE_W-1:0];
	assign s_sel = start_q[bank][lane*COEF_W +: COEF_W];
	assign e_sel = end_q[bank][lane*COEF_W +: COEF_W];

	// bit-serial multiply, msb first: acc = end*frames + (start-end)*count
	assign add_e    = f_sh_q[FRAME_W-1] ? NUM_W'(e_q) : '0;
	assign add_d    = c_sh_q[FRAME_W-1] ? NUM_W'(d_q) : '0;
	assign acc_next = (acc_q <<< 1) + add_e + add_d;
	assign acc_abs  = acc_q[NUM_W-1] ? -acc_q : acc_q;

	// restoring divide, one quotient bit per cycle
	assign shifted = {rem_q, dvd_q[MAG_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, frames_q};
	assign q_bit   = !diff[FRAME_W+1];
	assign q_mag   = dvd_q[COEF_W-1:0];
	assign q_val   = (frames_q == '0) ? e_q : (neg_q ? -$signed(q_mag) : $signed(q_mag));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (tick_xfer && eff_fading) state_d = ST_LOAD;
			ST_LOAD: state_d = ST_MUL;
			ST_MUL:  if (mul_last) state_d = ST_ABS;
			ST_ABS:  state_d = ST_DIV;
			ST_DIV:  if (div_last) state_d = ST_PUT;
			ST_PUT: begin
				if (out_free) state_d = idx_last ? ST_IDLE : ST_LOAD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// controller outputs
	always_comb begin
		tick.ready = 1'b0;
		load_out   = 1'b0;
		unique case (state_q)
			ST_IDLE: tick.ready = 1'b1;
			ST_PUT:  load_out   = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			start_q       <= '0;
			end_q         <= '0;
			fade_frames_q <= FADE_FRAMES_RESET;
			frames_left_q <= '0;
			fading_q      <= 1'b0;
			idx_q         <= '0;
			step_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				unique case (cfg_sel)
					REG_START_LOW:   start_q[0]    <= pwdata;
					REG_START_MID:   start_q[1]    <= pwdata;
					REG_START_HIGH:  start_q[2]    <= pwdata;
					REG_END_LOW:     end_q[0]      <= pwdata;
					REG_END_MID:     end_q[1]      <= pwdata;
					REG_END_HIGH:    end_q[2]      <= pwdata;
					REG_FADE_FRAMES: fade_frames_q <= pwdata[FRAME_W-1:0];
					default: ;
				endcase
			end
			if (tick_xfer && eff_fading) begin
				fading_q      <= (eff_left != '0);
				frames_left_q <= (eff_left == '0) ? eff_left : eff_left - FRAME_W'(1);
				idx_q         <= '0;
			end
			if (state_q == ST_LOAD || state_q == ST_ABS) begin
				step_q <= '0;
			end else if (state_q == ST_MUL || state_q == ST_DIV) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (load_out && !idx_last) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (coef.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (tick_xfer && eff_fading) begin
			count_q  <= eff_left;
			frames_q <= fade_frames_q;
			done_q   <= (eff_left == '0);
		end
		unique case (state_q)
			ST_LOAD: begin
				e_q    <= e_sel;
				d_q    <= (COEF_W+1)'(s_sel) - (COEF_W+1)'(e_sel);
				f_sh_q <= frames_q;
				c_sh_q <= count_q;
				acc_q  <= '0;
			end
			ST_MUL: begin
				acc_q  <= acc_next;
				f_sh_q <= {f_sh_q[FRAME_W-2:0], 1'b0};
				c_sh_q <= {c_sh_q[FRAME_W-2:0], 1'b0};
			end
			ST_ABS: begin
				dvd_q <= acc_abs[MAG_W-1:0];
				neg_q <= acc_q[NUM_W-1];
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= q_bit ? diff[FRAME_W-1:0] : shifted[FRAME_W-1:0];
				dvd_q <= {dvd_q[MAG_W-2:0], q_bit};
			end
			default: ;
		endcase
		if (load_out) begin
			out_idx_q  <= idx_q;
			out_val_q  <= q_val;
			out_last_q <= idx_last;
			out_done_q <= done_q;
		end
	end

	assign coef.valid         = out_valid_q;
	assign coef.coef_index    = out_idx_q;
	assign coef.coef_value    = out_val_q;
	assign coef.last_of_frame = out_last_q;
	assign coef.fade_done     = out_done_q;

	// checks
	a_idle_tick_no_work: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_xfer && !tick.restart && !fading_q) |=> (state_q == ST_IDLE))
		else $error("idle tick started a computation");

	a_restart_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_xfer && tick.restart && fade_frames_q != '0) |=>
		(fading_q && frames_left_q == $past(fade_frames_q) - FRAME_W'(1)))
		else $error("restart did not load the frame counter");

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && frames_q != '0) |-> (rem_q < frames_q))
		else $error("divider remainder not below divisor");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(coef.valid && coef.last_of_frame) |-> (coef.coef_index == IDX_W'(NUM_COEFS - 1)))
		else $error("last_of_frame on wrong coefficient");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (idx_q < IDX_W'(NUM_COEFS)))
		else $error("coefficient index out of range");

endmodule
